[hw/rtl/osis_pkg.sv]
// ----------------------------------------------------------------------------
// osis_pkg: shared types and constants for the ordered set unit
// Holds the request and response beat layouts, the command and status
// codes, and the default store capacity.
// ----------------------------------------------------------------------------
package osis_pkg;

    // key width; the response answer is one bit wider and signed
    localparam int KEY_BITS = 30;
    localparam int DEFAULT_CAPACITY = 1024;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic                cmd;
        logic [KEY_BITS-1:0] key_in;
    } osis_req_t;

    typedef struct packed {
        logic signed [KEY_BITS:0] answer;
        logic [1:0]               status;
    } osis_rsp_t;

    // result handed from the sequencer to the output stage
    typedef struct packed {
        logic      valid;
        osis_rsp_t item;
    } osis_res_t;

endpackage

[hw/rtl/ordered_set_insert_successor_unit.sv]
// ----------------------------------------------------------------------------
// ordered_set_insert_successor_unit: bounded ordered set with lower bound
// Stores up to CAPACITY distinct keys in a sorted RAM. Insert beats add a
// key (duplicates and inserts into a full set are reported); query beats
// return the smallest stored key not below the given one, or -1.
// ----------------------------------------------------------------------------
// One item is handled at a time. The binary search runs through the single
// read port of the key RAM and one comparator; an insert of a new key then
// shifts every larger key up one slot, each move taking a read state and a
// write state, and then writes the new key into the open slot. The finished
// response sits in an output register, and the next request beat is taken
// while it waits.
module ordered_set_insert_successor_unit
    import osis_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  osis_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output osis_rsp_t rsp
);

    logic      seq_idle;
    logic      res_take;
    osis_res_t res;
    logic      rsp_valid_reg;
    osis_rsp_t rsp_reg;

    osis_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (req_valid && seq_idle),
        .req      (req),
        .idle     (seq_idle),
        .res      (res),
        .res_take (res_take)
    );

    // request side: take a beat whenever the sequencer is free
    assign req_stall = !seq_idle;

    // response register: loads when empty or being drained
    assign res_take = res.valid && (!rsp_valid_reg || !rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_take)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res.item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[hw/rtl/osis_ram.sv]
// ----------------------------------------------------------------------------
// osis_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module osis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/osis_seq.sv]
// ----------------------------------------------------------------------------
// osis_seq: search and shift sequencer
// Binary search over the sorted key store through one read port and one
// comparator, then for a new key a descending shift to open a slot.
// ----------------------------------------------------------------------------
module osis_seq
    import osis_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  osis_req_t req,
    output logic      idle,
    output osis_res_t res,
    input  logic      res_take
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [CW-1:0]           lo_reg;
    logic [CW-1:0]           hi_reg;
    logic [CW-1:0]           occ_reg;
    logic [CW-1:0]           idx_reg;
    logic                    cmd_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic signed [KEY_BITS:0] answer_reg;
    logic [1:0]              status_reg;

    logic [CW-1:0]       mid;
    logic [CW-1:0]       idx_dec;
    logic                pos_valid;
    logic                key_less;
    logic                key_equal;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    osis_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared comparator and index arithmetic
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_dec   = idx_reg - CW'(1);
    assign pos_valid = (lo_reg < occ_reg);
    assign key_less  = (ram_rdata < key_reg);
    assign key_equal = (ram_rdata == key_reg);

    // store port control
    always_comb
    begin
        ram_raddr = lo_reg[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = ram_rdata;
        case (state_reg)
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_raddr = mid[AW-1:0];
                end
            end
            S_SHIFT_RD:
            begin
                ram_raddr = idx_dec[AW-1:0];
                if (idx_reg <= lo_reg)
                begin
                    // slot is open: place the new key
                    ram_we    = 1'b1;
                    ram_waddr = lo_reg[AW-1:0];
                    ram_wdata = key_reg;
                end
            end
            S_SHIFT_WR:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            idx_reg    <= '0;
            cmd_reg    <= CMD_INSERT;
            key_reg    <= '0;
            answer_reg <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= req.cmd;
                        key_reg   <= req.key_in;
                        lo_reg    <= '0;
                        hi_reg    <= occ_reg;
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    // read of mid (or of the final position) issued here
                    if (lo_reg < hi_reg)
                    begin
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_CMP:
                begin
                    if (key_less)
                    begin
                        lo_reg <= mid + CW'(1);
                    end
                    else
                    begin
                        hi_reg <= mid;
                    end
                    state_reg <= S_SEARCH;
                end
                S_DECIDE:
                begin
                    if (cmd_reg == CMD_QUERY)
                    begin
                        status_reg <= ST_OK;
                        if (pos_valid)
                        begin
                            answer_reg <= signed'({1'b0, ram_rdata});
                        end
                        else
                        begin
                            answer_reg <= '1;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (pos_valid && key_equal)
                    begin
                        answer_reg <= '0;
                        status_reg <= ST_DUP;
                        state_reg  <= S_DONE;
                    end
                    else if (occ_reg == CW'(CAPACITY))
                    begin
                        answer_reg <= '0;
                        status_reg <= ST_FULL;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        answer_reg <= '0;
                        status_reg <= ST_OK;
                        idx_reg    <= occ_reg;
                        state_reg  <= S_SHIFT_RD;
                    end
                end
                S_SHIFT_RD:
                begin
                    if (idx_reg <= lo_reg)
                    begin
                        occ_reg   <= occ_reg + CW'(1);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR:
                begin
                    // entry idx-1 moved up to idx
                    idx_reg   <= idx_dec;
                    state_reg <= S_SHIFT_RD;
                end
                S_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle            = (state_reg == S_IDLE);
    assign res.valid       = (state_reg == S_DONE);
    assign res.item.answer = answer_reg;
    assign res.item.status = status_reg;

endmodule

[tb/ordered_set_insert_successor_unit_test.sv]
// ----------------------------------------------------------------------------
// ordered_set_insert_successor_unit_test: self-checking bench for the set unit
// Drives insert and query beats into the unit and keeps a sorted mirror of
// the stored keys to predict each response. Covers the empty set, extreme
// and alternating-bit keys, duplicates, random growth, output backpressure,
// filling to capacity, and random traffic against a full set.
// ----------------------------------------------------------------------------
module ordered_set_insert_successor_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import osis_pkg::*;

    localparam int CAPACITY = DEFAULT_CAPACITY;
    localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
    // ascending fill keys sit near the top so each insert shifts almost nothing
    localparam logic [KEY_BITS-1:0] FILL_BASE = KEY_BITS'(KEY_MAX - 4 * CAPACITY);
    localparam int IDLE_PCT = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 50;
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    osis_req_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    osis_rsp_t rsp;

    // sorted mirror of the keys held by the unit
    logic [KEY_BITS-1:0] stored_keys[$];
    // responses still owed by the unit, oldest first
    osis_rsp_t           expected_rsps[$];

    bit     idle_en = 1'b1;
    int     hold_request = 0;
    int     err_count = 0;
    longint cycle_count = 0;

    ordered_set_insert_successor_unit #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Apply one beat to the mirror and return the response it should produce
    function automatic osis_rsp_t apply_to_set(osis_req_t item);
        osis_rsp_t result;
        int        pos;
        result.answer = '0;
        result.status = ST_OK;
        pos = 0;
        while (pos < stored_keys.size() && stored_keys[pos] < item.key_in)
            pos++;
        if (item.cmd == CMD_QUERY)
        begin
            if (pos < stored_keys.size())
                result.answer = {1'b0, stored_keys[pos]};
            else
                result.answer = '1;
        end
        else if (pos < stored_keys.size() && stored_keys[pos] == item.key_in)
            result.status = ST_DUP;
        else if (stored_keys.size() >= CAPACITY)
            result.status = ST_FULL;
        else
            stored_keys.insert(pos, item.key_in);
        return result;
    endfunction

    // Offer one beat, with an optional random gap first; predict on accept
    task automatic send_item(input logic cmd, input logic [KEY_BITS-1:0] key);
        osis_req_t item;
        item.cmd = cmd;
        item.key_in = key;
        while (idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_stall);
        expected_rsps.push_back(apply_to_set(item));
    endtask

    // Stop offering and wait until every owed response has come back
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rsps.size() != 0);
    endtask

    // Mixed inserts and queries; keys are fully random or near a stored key
    task automatic run_random_items(input int count);
        logic                cmd;
        logic [KEY_BITS-1:0] key;
        int                  idx;
        for (int i = 0; i < count; i++)
        begin
            // a long stretch with no idling on either side
            idle_en = !(i >= 100 && i < 180);
            cmd = ($urandom_range(99) < 55) ? CMD_INSERT : CMD_QUERY;
            if (stored_keys.size() != 0 && $urandom_range(99) < 40)
            begin
                idx = $urandom_range(stored_keys.size() - 1);
                key = KEY_BITS'(stored_keys[idx] + $urandom_range(2) - 1);
            end
            else
                key = KEY_BITS'($urandom);
            send_item(cmd, key);
        end
        idle_en = 1'b1;
    endtask

    // Queries against an empty set all miss
    task automatic test_empty_queries();
        send_item(CMD_QUERY, '0);
        send_item(CMD_QUERY, KEY_MAX);
        send_item(CMD_QUERY, KEY_BITS'('h2AAA_AAAA));
    endtask

    // Smallest and largest keys, their lower bounds and duplicates
    task automatic test_extreme_keys();
        send_item(CMD_INSERT, '0);
        send_item(CMD_INSERT, KEY_MAX);
        send_item(CMD_QUERY, '0);
        send_item(CMD_QUERY, KEY_BITS'(1));
        send_item(CMD_QUERY, KEY_MAX);
        send_item(CMD_INSERT, '0);
        send_item(CMD_INSERT, KEY_MAX);
    endtask

    // Alternating bit patterns: exact hits, just-above, and between keys
    task automatic test_alternating_bits();
        send_item(CMD_INSERT, KEY_BITS'('h1555_5555));
        send_item(CMD_INSERT, KEY_BITS'('h2AAA_AAAA));
        send_item(CMD_QUERY, KEY_BITS'('h1555_5555));
        send_item(CMD_QUERY, KEY_BITS'('h1555_5556));
        send_item(CMD_QUERY, KEY_BITS'('h2AAA_AAAB));
        send_item(CMD_INSERT, KEY_BITS'('h1555_5555));
    endtask

    // Random traffic while the set grows
    task automatic test_random_growth();
        run_random_items(120);
    endtask

    // Receiver holds off for a long stretch while beats keep coming, then
    // the sender pauses until every response is back
    task automatic test_output_hold();
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 12; i++)
            send_item((i % 3 == 0) ? CMD_INSERT : CMD_QUERY, KEY_BITS'($urandom));
        wait_for_drain();
        for (int i = 0; i < 4; i++)
            send_item(CMD_QUERY, KEY_BITS'($urandom));
    endtask

    // Fill with ascending keys, then hit the full-set corner cases
    task automatic test_fill_to_capacity();
        for (int i = 0; stored_keys.size() < CAPACITY; i++)
            send_item(CMD_INSERT, KEY_BITS'(FILL_BASE + i));
        // new key while full is dropped
        send_item(CMD_INSERT, KEY_BITS'(FILL_BASE - 1));
        send_item(CMD_INSERT, KEY_BITS'(KEY_MAX - 1));
        // duplicate while full still reports as duplicate
        send_item(CMD_INSERT, '0);
        send_item(CMD_INSERT, KEY_MAX);
        send_item(CMD_QUERY, KEY_BITS'(KEY_MAX - 1));
        send_item(CMD_QUERY, FILL_BASE);
    endtask

    // Random traffic against a full set
    task automatic test_random_full();
        run_random_items(60);
    endtask

    // Receiver stall: random idling, or a long hold when one is requested
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
                rsp_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Response check against the oldest owed beat
    always @(posedge clk)
    begin
        osis_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, got answer %0d status %0d",
                         $time, rsp.answer, rsp.status);
                err_count++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.answer !== want.answer)
                begin
                    $display("%0t: answer expected %0d, got %0d",
                             $time, want.answer, rsp.answer);
                    err_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, rsp.status);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ordered_set_insert_successor_unit: mismatch");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queries();
        test_extreme_keys();
        test_alternating_bits();
        test_random_growth();
        test_output_hold();
        test_fill_to_capacity();
        test_random_full();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && expected_rsps.size() == 0)
            $display("ordered_set_insert_successor_unit: match");
        else
            $display("ordered_set_insert_successor_unit: mismatch");
        $finish;
    end

endmodule
